/* rtl/mcjs_pkg.sv */
// Shared types and constants of the memory-constrained job scheduler.
package mcjs_pkg;

   localparam int PendDepth = 32;
   localparam int RunSlots  = 32;
   localparam int MaxOut    = 32;
   localparam int PendIdxW  = $clog2(PendDepth);
   localparam int PendCntW  = $clog2(PendDepth + 1);
   localparam int SlotW     = $clog2(RunSlots);
   localparam int OutIdxW   = $clog2(MaxOut);
   localparam int OutCntW   = $clog2(MaxOut + 1);
   localparam int UsedW     = 8 + $clog2(RunSlots + 1);

   localparam logic [7:0] TotalFramesReset = 8'd32;

   localparam logic       CMD_SUBMIT = 1'b0;
   localparam logic       CMD_TICK   = 1'b1;

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   localparam logic       REG_TOTAL_FRAMES = 1'b0;
   localparam logic       REG_ADMIT_MODE   = 1'b1;

   typedef struct packed {
      logic [7:0] id;
      logic [7:0] pages;
      logic [7:0] dur;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADM_SCAN,
      ST_ADM_MOVE,
      ST_RET_SCAN,
      ST_COUNT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_step;
      logic admit;
      logic ret_start;
      logic ret_step;
      logic countdown;
      logic out_step;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic pend_empty;
      logic slot_free;
      logic scan_last;
      logic found;
      logic ret_hit;
      logic ret_cap;
      logic slot_last;
      logic any_ret;
      logic out_last;
   } sts_type;

endpackage

/* rtl/mcjs_ctrl.sv */
// Sequencer of the scheduler: admission, retirement, countdown and result output.
module mcjs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic              rsp_fire,
   input  mcjs_pkg::sts_type sts,
   output mcjs_pkg::cmd_type cmd,
   output logic              in_ready,
   output logic              out_valid
);

   mcjs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcjs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcjs_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = sts.is_tick ? mcjs_pkg::ST_ADM_SCAN : mcjs_pkg::ST_OUT;
            end
         end
         mcjs_pkg::ST_ADM_SCAN: begin
            if (sts.pend_empty || !sts.slot_free) begin
               state_in = mcjs_pkg::ST_RET_SCAN;
            end else if (sts.scan_last) begin
               state_in = mcjs_pkg::ST_ADM_MOVE;
            end
         end
         mcjs_pkg::ST_ADM_MOVE: begin
            state_in = sts.found ? mcjs_pkg::ST_ADM_SCAN : mcjs_pkg::ST_RET_SCAN;
         end
         mcjs_pkg::ST_RET_SCAN: begin
            if (sts.ret_hit && sts.ret_cap) begin
               state_in = mcjs_pkg::ST_OUT;
            end else if (sts.slot_last) begin
               state_in = (sts.any_ret || sts.ret_hit) ? mcjs_pkg::ST_ADM_SCAN
                                                       : mcjs_pkg::ST_COUNT;
            end
         end
         mcjs_pkg::ST_COUNT: begin
            state_in = mcjs_pkg::ST_OUT;
         end
         mcjs_pkg::ST_OUT: begin
            if (rsp_fire && sts.out_last) begin
               state_in = mcjs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcjs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         mcjs_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = req_fire;
         end
         mcjs_pkg::ST_ADM_SCAN: begin
            if (sts.pend_empty || !sts.slot_free) begin
               cmd.ret_start = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         mcjs_pkg::ST_ADM_MOVE: begin
            cmd.admit      = sts.found;
            cmd.scan_start = sts.found;
            cmd.ret_start  = !sts.found;
         end
         mcjs_pkg::ST_RET_SCAN: begin
            cmd.ret_step = 1'b1;
            // A full pass that retired something goes back to admission.
            cmd.scan_start = sts.slot_last && (sts.any_ret || sts.ret_hit);
         end
         mcjs_pkg::ST_COUNT: begin
            cmd.countdown = 1'b1;
         end
         mcjs_pkg::ST_OUT: begin
            out_valid    = 1'b1;
            cmd.out_step = rsp_fire;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/mcjs_dp.sv */
// Datapath of the scheduler: job tables, frame accounting, result buffer.
module mcjs_dp (
   input  logic              clock,
   input  logic              reset,
   input  mcjs_pkg::cmd_type cmd,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata,
   input  logic              in_command,
   input  logic [7:0]        in_job_id,
   input  logic [7:0]        in_pages,
   input  logic [7:0]        in_duration,
   output mcjs_pkg::sts_type sts,
   output logic [1:0]        out_kind,
   output logic [7:0]        out_done_id,
   output logic              out_done_valid,
   output logic [7:0]        out_frames_free,
   output logic [15:0]       out_elapsed,
   output logic              out_idle,
   output logic              out_last
);

   localparam int PD = mcjs_pkg::PendDepth;
   localparam int RS = mcjs_pkg::RunSlots;

   mcjs_pkg::job_type                   pend_ff [PD];
   mcjs_pkg::job_type                   pend_in [PD];
   mcjs_pkg::job_type                   run_ff  [RS];
   mcjs_pkg::job_type                   run_in  [RS];
   logic [RS-1:0]                       valid_ff, valid_in;
   logic [mcjs_pkg::PendCntW-1:0]       count_ff, count_in;
   logic [mcjs_pkg::UsedW-1:0]          used_ff, used_in;
   logic [15:0]                         time_ff, time_in;
   logic [7:0]                          total_ff, total_in;
   logic                                mode_ff, mode_in;
   logic                                tick_ff, tick_in;
   logic [1:0]                          kind_ff, kind_in;
   logic [mcjs_pkg::PendIdxW-1:0]       idx_ff, idx_in;
   logic [mcjs_pkg::PendIdxW-1:0]       pick_ff, pick_in;
   logic [7:0]                          best_ff, best_in;
   logic                                found_ff, found_in;
   logic [mcjs_pkg::SlotW-1:0]          slot_ff, slot_in;
   logic                                any_ff, any_in;
   logic [7:0]                          res_ff [mcjs_pkg::MaxOut];
   logic [7:0]                          res_in [mcjs_pkg::MaxOut];
   logic [mcjs_pkg::OutCntW-1:0]        n_ff, n_in;
   logic [mcjs_pkg::OutIdxW-1:0]        k_ff, k_in;

   logic [7:0]                    free_frames;
   logic [mcjs_pkg::SlotW-1:0]    free_slot;
   logic                          has_free;
   logic                          fits;
   logic                          submit_ok;
   logic                          hit;
   mcjs_pkg::job_type             scan_job;
   mcjs_pkg::job_type             pick_job;
   mcjs_pkg::job_type             cur_run;

   always_comb begin
      if (used_ff < {{(mcjs_pkg::UsedW-8){1'b0}}, total_ff}) begin
         free_frames = total_ff - used_ff[7:0];
      end else begin
         free_frames = '0;
      end
   end

   // Lowest run slot that is not in use.
   always_comb begin
      free_slot = '0;
      has_free  = 1'b0;
      for (int s = RS - 1; s >= 0; s--) begin
         if (!valid_ff[s]) begin
            free_slot = mcjs_pkg::SlotW'(s);
            has_free  = 1'b1;
         end
      end
   end

   assign scan_job  = pend_ff[idx_ff];
   assign pick_job  = pend_ff[pick_ff];
   assign cur_run   = run_ff[slot_ff];
   assign fits      = scan_job.pages <= free_frames;
   assign hit       = valid_ff[slot_ff] && (cur_run.dur == 8'd0);
   assign submit_ok = (in_pages != 8'd0) && (in_pages <= total_ff)
                      && (count_ff < mcjs_pkg::PendCntW'(PD));

   always_comb begin
      pend_in  = pend_ff;
      run_in   = run_ff;
      valid_in = valid_ff;
      count_in = count_ff;
      used_in  = used_ff;
      time_in  = time_ff;
      total_in = total_ff;
      mode_in  = mode_ff;
      tick_in  = tick_ff;
      kind_in  = kind_ff;
      idx_in   = idx_ff;
      pick_in  = pick_ff;
      best_in  = best_ff;
      found_in = found_ff;
      slot_in  = slot_ff;
      any_in   = any_ff;
      res_in   = res_ff;
      n_in     = n_ff;
      k_in     = k_ff;

      if (csr_we) begin
         case (csr_index)
            mcjs_pkg::REG_TOTAL_FRAMES: total_in = csr_wdata;
            mcjs_pkg::REG_ADMIT_MODE:   mode_in  = csr_wdata[0];
            default:                    total_in = total_ff;
         endcase
      end

      if (cmd.load) begin
         tick_in  = in_command == mcjs_pkg::CMD_TICK;
         n_in     = '0;
         k_in     = '0;
         idx_in   = '0;
         best_in  = '0;
         found_in = 1'b0;
         if (in_command == mcjs_pkg::CMD_SUBMIT) begin
            kind_in = submit_ok ? mcjs_pkg::KIND_ACCEPT : mcjs_pkg::KIND_REJECT;
            if (submit_ok) begin
               pend_in[count_ff[mcjs_pkg::PendIdxW-1:0]] = '{id: in_job_id,
                  pages: in_pages, dur: in_duration};
               count_in = count_ff + 1'b1;
            end
         end else begin
            kind_in = mcjs_pkg::KIND_TICK;
         end
      end

      if (cmd.scan_start) begin
         idx_in   = '0;
         best_in  = '0;
         found_in = 1'b0;
      end

      if (cmd.scan_step) begin
         if (mode_ff) begin
            if (fits && scan_job.pages >= best_ff) begin
               best_in  = scan_job.pages;
               pick_in  = idx_ff;
               found_in = 1'b1;
            end
         end else if (fits) begin
            pick_in  = '0;
            found_in = 1'b1;
         end
         idx_in = idx_ff + 1'b1;
      end

      if (cmd.admit) begin
         run_in[free_slot]   = pick_job;
         valid_in[free_slot] = 1'b1;
         used_in = used_ff + {{(mcjs_pkg::UsedW-8){1'b0}}, pick_job.pages};
         for (int i = 0; i < PD - 1; i++) begin
            if (mcjs_pkg::PendIdxW'(i) >= pick_ff) begin
               pend_in[i] = pend_ff[i+1];
            end
         end
         count_in = count_ff - 1'b1;
      end

      if (cmd.ret_start) begin
         slot_in = '0;
         any_in  = 1'b0;
      end

      if (cmd.ret_step) begin
         slot_in = slot_ff + 1'b1;
         if (hit) begin
            valid_in[slot_ff] = 1'b0;
            used_in = used_ff - {{(mcjs_pkg::UsedW-8){1'b0}}, cur_run.pages};
            res_in[n_ff[mcjs_pkg::OutIdxW-1:0]] = cur_run.id;
            n_in    = n_ff + 1'b1;
            any_in  = 1'b1;
         end
         if (cmd.scan_start) begin
            slot_in = '0;
            any_in  = 1'b0;
         end
      end

      if (cmd.countdown && (valid_ff != '0)) begin
         for (int s = 0; s < RS; s++) begin
            if (valid_ff[s] && run_ff[s].dur != 8'd0) begin
               run_in[s].dur = run_ff[s].dur - 1'b1;
            end
         end
         if (time_ff != 16'hFFFF) begin
            time_in = time_ff + 1'b1;
         end
      end

      if (cmd.out_step) begin
         k_in = k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         used_ff  <= '0;
         time_ff  <= '0;
         total_ff <= mcjs_pkg::TotalFramesReset;
         mode_ff  <= 1'b0;
         tick_ff  <= 1'b0;
         found_ff <= 1'b0;
         any_ff   <= 1'b0;
         n_ff     <= '0;
         k_ff     <= '0;
         idx_ff   <= '0;
         slot_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         used_ff  <= used_in;
         time_ff  <= time_in;
         total_ff <= total_in;
         mode_ff  <= mode_in;
         tick_ff  <= tick_in;
         found_ff <= found_in;
         any_ff   <= any_in;
         n_ff     <= n_in;
         k_ff     <= k_in;
         idx_ff   <= idx_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      run_ff  <= run_in;
      res_ff  <= res_in;
      kind_ff <= kind_in;
      pick_ff <= pick_in;
      best_ff <= best_in;
   end

   assign sts.is_tick    = in_command == mcjs_pkg::CMD_TICK;
   assign sts.pend_empty = count_ff == '0;
   assign sts.slot_free  = has_free;
   assign sts.scan_last  = mode_ff ? ({1'b0, idx_ff} == count_ff - 1'b1) : 1'b1;
   assign sts.found      = found_ff;
   assign sts.ret_hit    = hit;
   assign sts.ret_cap    = n_ff == mcjs_pkg::OutCntW'(mcjs_pkg::MaxOut - 1);
   assign sts.slot_last  = slot_ff == mcjs_pkg::SlotW'(RS - 1);
   assign sts.any_ret    = any_ff;
   assign sts.out_last   = out_last;

   assign out_kind        = kind_ff;
   assign out_done_valid  = tick_ff && (n_ff != '0);
   assign out_done_id     = out_done_valid ? res_ff[k_ff] : 8'd0;
   assign out_frames_free = free_frames;
   assign out_elapsed     = time_ff;
   assign out_idle        = (count_ff == '0) && (valid_ff == '0);
   assign out_last        = !out_done_valid || ({1'b0, k_ff} == n_ff - 1'b1);

endmodule

/* rtl/memory_constrained_job_scheduler.sv */
// Top level of the memory-constrained job scheduler.
// One request is taken at a time, and the next one is accepted only after the last
// result of the previous request has been taken. A submit is accepted and then gives
// a single result. A tick is accepted and then runs admission and retirement passes
// until a retirement scan finds nothing to retire. Each admission attempt scans the
// pending entries in turn (only the head entry in FIFO mode) and then admits the job
// it picked, if one fitted. An attempt with no pending job or no free run slot goes
// straight to retirement. Each retirement scan visits every run slot in turn, and
// stops early once 32 jobs have been retired. A tick that settles then runs one
// countdown step. Results then go out in turn, each held until the receiver takes it.
// All results of a request carry the frame count, elapsed time and idle flag as they
// stand once the whole request is done.
module memory_constrained_job_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // job_id, pages, duration
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // done_id, done_valid, frames_free, elapsed, idle, zeros
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   mcjs_pkg::cmd_type cmd;
   mcjs_pkg::sts_type sts;
   logic              req_fire;
   logic              rsp_fire;
   logic [7:0]        done_id;
   logic              done_valid;
   logic [7:0]        frames_free;
   logic [15:0]       elapsed;
   logic              idle;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   mcjs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .rsp_fire  (rsp_fire),
      .sts       (sts),
      .cmd       (cmd),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid)
   );

   mcjs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .in_command      (req_tuser),
      .in_job_id       (req_tdata[7:0]),
      .in_pages        (req_tdata[15:8]),
      .in_duration     (req_tdata[23:16]),
      .sts             (sts),
      .out_kind        (rsp_tuser),
      .out_done_id     (done_id),
      .out_done_valid  (done_valid),
      .out_frames_free (frames_free),
      .out_elapsed     (elapsed),
      .out_idle        (idle),
      .out_last        (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, idle, elapsed, frames_free, done_valid, done_id};

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a result is pending");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("ready right after a request");

   a_done_is_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && done_valid) |-> (rsp_tuser == mcjs_pkg::KIND_TICK))
      else $error("retired job reported outside a tick");
`endif

endmodule
